// ===== rtl/bmsz_pkg.sv =====
// Shared constants for the skip-zero boxcar mean block.
// No dependencies; compiled before every other file of the block.
package bmsz_pkg;

	// Default build values for the top level parameters.
	localparam int MAX_HALF_WIDTH_DEF = 32;
	localparam int SAMPLE_BITS_DEF    = 32;

	// Width and reset value of the half width register.
	localparam int          HW_BITS  = 6;
	localparam logic [5:0]  HW_RESET = 6'd1;

endpackage

// ===== rtl/bmsz_ifs.sv =====
// Channel interfaces of the skip-zero boxcar mean block: samples, means and
// the half width register write. Depends on bmsz_pkg.
interface bmsz_in_if #(
	parameter int SAMPLE_BITS = bmsz_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface bmsz_out_if #(
	parameter int SAMPLE_BITS = bmsz_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] mean;
	logic                          last_result;

	modport source (output valid, output mean, output last_result, input ready);
	modport sink   (input valid, input mean, input last_result, output ready);
endinterface

interface bmsz_cfg_if;
	import bmsz_pkg::*;

	logic               valid;
	logic               ready;
	logic [HW_BITS-1:0] half_width;

	modport source (output valid, output half_width, input ready);
	modport sink   (input valid, input half_width, output ready);
endinterface

// ===== rtl/boxcar_mean_skip_zero.sv =====
// Skip-zero centred boxcar mean over a sample vector, window held in one RAM.
// Depends on bmsz_pkg and the channel interfaces in bmsz_ifs.sv.
//
//  channel   dir   handshake      word
//  samples   in    valid/ready    sample, last_sample
//  means     out   valid/ready    mean, last_result
//  cfg       in    valid/ready    half_width (always ready)
//
// A sample word is taken only while idle, so no new sample is taken until the
// means it causes are handed to the output register: one window RAM read per
// sample in the window, then a restoring divider that retires one quotient bit
// a cycle.
// A window with no nonzero sample skips the divider.
// A last sample flushes up to half_width + 1 means in turn.
// Reset is asynchronous and clears all control state; the window RAM is not
// cleared, as only entries of the current vector are read.
// A stalled mean waits in the output register; new samples are taken while it waits.
module boxcar_mean_skip_zero #(
	parameter int MAX_HALF_WIDTH = bmsz_pkg::MAX_HALF_WIDTH_DEF,
	parameter int SAMPLE_BITS    = bmsz_pkg::SAMPLE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bmsz_in_if.sink    samples,
	bmsz_out_if.source means,
	bmsz_cfg_if.sink   cfg
);
	import bmsz_pkg::*;

	localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int SUM_W = SAMPLE_BITS + CW;
	localparam int DCW   = $clog2(SUM_W);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SWEEP = 6'b000010,
		S_DRAIN = 6'b000100,
		S_PREP  = 6'b001000,
		S_DIV   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t                    state_q;
	logic [HW_BITS-1:0]        hw_q;
	logic [AW-1:0]             wp_q;
	logic [CW-1:0]             seen_q;
	logic [AW-1:0]             newest_q;
	logic [CW-1:0]             h_q;
	logic [CW-1:0]             c_q;
	logic [CW-1:0]             center_q;
	logic                      flush_q;
	logic [AW-1:0]             rd_addr_q;
	logic [CW-1:0]             age_q;
	logic [CW-1:0]             oldest_q;
	logic                      rd_vld_s1;
	logic [SAMPLE_BITS-1:0]    rd_data_s1;
	logic signed [SUM_W-1:0]   sum_q;
	logic [CW-1:0]             cnt_q;
	logic                      neg_q;
	logic [SUM_W-1:0]          qr_q;
	logic [CW-1:0]             rem_q;
	logic [DCW-1:0]            div_cnt_q;
	logic signed [SAMPLE_BITS-1:0] mean_q;
	logic                      last_res_q;
	logic                      out_vld_q;

	logic [SAMPLE_BITS-1:0]    win_mem [DEPTH];

	logic                      in_acc;
	logic [CW-1:0]             h_eff;
	logic [CW-1:0]             c_new;
	logic [CW-1:0]             c_m1;
	logic [CW-1:0]             top;
	logic [CW-1:0]             reach_top;
	logic [CW-1:0]             oldest_first;
	logic [CW-1:0]             center_nx;
	logic [CW-1:0]             reach_nx;
	logic [CW-1:0]             oldest_nx;
	logic [SUM_W-1:0]          sum_mag;
	logic [CW:0]               trial;
	logic                      trial_ge;
	logic [SUM_W-1:0]          quot;
	logic                      out_free;
	logic                      out_load;

	assign samples.ready = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;
	assign in_acc        = samples.valid && samples.ready;

	assign means.valid       = out_vld_q;
	assign means.mean        = mean_q;
	assign means.last_result = last_res_q;

	// Effective half width, saturated at the build maximum.
	assign h_eff = (32'(hw_q) > 32'(MAX_HALF_WIDTH)) ? CW'(MAX_HALF_WIDTH) : CW'(hw_q);

	// Sample count after this word, saturating at the window depth.
	assign c_new = (seen_q < CW'(DEPTH)) ? seen_q + 1'b1 : seen_q;
	assign c_m1  = c_new - 1'b1;

	// Window of the first result: a plain step reaches 2h back, a flush
	// starts its centre at min(h, c-1) and reaches h past it.
	assign top       = (h_eff < c_m1) ? h_eff : c_m1;
	assign reach_top = top + h_eff;
	always_comb begin
		if (samples.last_sample) begin
			oldest_first = (reach_top < c_m1) ? reach_top : c_m1;
		end else begin
			oldest_first = ((h_eff << 1) < c_m1) ? (h_eff << 1) : c_m1;
		end
	end

	// Window of the next flushed result.
	assign center_nx = center_q - 1'b1;
	assign reach_nx  = center_nx + h_q;
	assign oldest_nx = (reach_nx < (c_q - 1'b1)) ? reach_nx : (c_q - 1'b1);

	// Divider step and final sign fix.
	assign sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign trial    = {rem_q, qr_q[SUM_W-1]};
	assign trial_ge = (trial >= {1'b0, cnt_q});
	assign quot     = neg_q ? (~qr_q + 1'b1) : qr_q;
	assign out_free = !out_vld_q || means.ready;
	assign out_load = (state_q == S_OUT) && out_free;

	// Window RAM: written on sample acceptance, read one address a cycle.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			win_mem[wp_q] <= samples.sample;
		end
		rd_data_s1 <= win_mem[rd_addr_q];
	end

	// Half width register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= HW_RESET;
		end else if (cfg.valid && cfg.ready) begin
			hw_q <= cfg.half_width;
		end
	end

	// Read valid for the registered RAM data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SWEEP);
		end
	end

	// Sequencer: accept, sweep the window, divide, hand over the mean.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			wp_q       <= '0;
			seen_q     <= '0;
			out_vld_q  <= 1'b0;
			flush_q    <= 1'b0;
			center_q   <= '0;
			age_q      <= '0;
			div_cnt_q  <= '0;
			newest_q   <= '0;
			rd_addr_q  <= '0;
			h_q        <= '0;
			c_q        <= '0;
			oldest_q   <= '0;
			sum_q      <= '0;
			cnt_q      <= '0;
			neg_q      <= 1'b0;
			qr_q       <= '0;
			rem_q      <= '0;
			mean_q     <= '0;
			last_res_q <= 1'b0;
		end else begin
			// The mean word stays valid until taken, and is reloaded from the divider.
			out_vld_q <= out_load || (out_vld_q && !means.ready);
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						newest_q  <= wp_q;
						rd_addr_q <= wp_q;
						h_q       <= h_eff;
						c_q       <= c_new;
						age_q     <= '0;
						oldest_q  <= oldest_first;
						center_q  <= samples.last_sample ? top : '0;
						flush_q   <= samples.last_sample;
						sum_q     <= '0;
						cnt_q     <= '0;
						if (samples.last_sample) begin
							wp_q    <= '0;
							seen_q  <= '0;
							state_q <= S_SWEEP;
						end else begin
							wp_q   <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
							seen_q <= c_new;
							if (c_new > h_eff) begin
								state_q <= S_SWEEP;
							end
						end
					end
				end
				S_SWEEP: begin
					rd_addr_q <= (rd_addr_q == '0) ? AW'(DEPTH - 1) : rd_addr_q - 1'b1;
					age_q     <= age_q + 1'b1;
					if (age_q == oldest_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_PREP;
				end
				S_PREP: begin
					rem_q     <= '0;
					div_cnt_q <= DCW'(SUM_W - 1);
					if (cnt_q == '0) begin
						qr_q    <= '0;
						neg_q   <= 1'b0;
						state_q <= S_OUT;
					end else begin
						qr_q    <= sum_mag;
						neg_q   <= sum_q[SUM_W-1];
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					qr_q      <= {qr_q[SUM_W-2:0], trial_ge};
					rem_q     <= trial_ge ? CW'(trial - {1'b0, cnt_q}) : trial[CW-1:0];
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						mean_q     <= quot[SAMPLE_BITS-1:0];
						last_res_q <= flush_q && (center_q == '0);
						if (flush_q && (center_q != '0)) begin
							center_q  <= center_nx;
							oldest_q  <= oldest_nx;
							rd_addr_q <= newest_q;
							age_q     <= '0;
							sum_q     <= '0;
							cnt_q     <= '0;
							state_q   <= S_SWEEP;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Accumulate nonzero samples as the RAM data returns.
			if (rd_vld_s1 && (rd_data_s1 != '0)) begin
				sum_q <= sum_q + SUM_W'(signed'(rd_data_s1));
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/bmsz_checker.sv =====
// Port-level checks for the skip-zero boxcar mean block, bound to its top level.
// Depends on bmsz_pkg and boxcar_mean_skip_zero.
module bmsz_assertions #(
	parameter int SAMPLE_BITS = bmsz_pkg::SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_mean,
	input logic                   out_last
);
	import bmsz_pkg::*;

	// A new mean word only appears while the input is closed for the work on it.
	a_rise_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("mean word appeared while the input was open");

	// No mean can appear in the cycle after a sample word is taken.
	a_no_instant_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("mean word appeared straight after a sample word");

	// A stalled mean word keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_mean) && $stable(out_last)))
		else $error("stalled mean word changed or was withdrawn");

endmodule

bind boxcar_mean_skip_zero bmsz_assertions #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_bmsz_assertions (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (means.valid),
	.out_ready (means.ready),
	.out_mean  (means.mean),
	.out_last  (means.last_result)
);
